// ===== rtl/psg_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psg_pkg
// Types, bus codes and register masks shared by the PSG bus interface.
// ----------------------------------------------------------------------------
package psg_pkg;

	localparam int REG_COUNT = 16;
	localparam int REG_IDX_W = $clog2(REG_COUNT);

	localparam logic [REG_IDX_W-1:0] MIXER_REG  = REG_IDX_W'(7);
	localparam logic [REG_IDX_W-1:0] PORT_A_REG = REG_IDX_W'(14);
	localparam logic [REG_IDX_W-1:0] PORT_B_REG = REG_IDX_W'(15);

	localparam int MIX_DIR_A_BIT = 6;
	localparam int MIX_DIR_B_BIT = 7;

	// BDIR/BC2/BC1 encodings
	localparam logic [2:0] BUS_LATCH_BC1  = 3'd1;
	localparam logic [2:0] BUS_LATCH_BDIR = 3'd4;
	localparam logic [2:0] BUS_LATCH_ALL  = 3'd7;
	localparam logic [2:0] BUS_READ       = 3'd3;
	localparam logic [2:0] BUS_WRITE      = 3'd6;

	localparam logic [1:0] CHIP_AY       = 2'd0;
	localparam logic [1:0] CHIP_AY8912   = 2'd1;
	localparam logic [1:0] CHIP_YMZ284   = 2'd2;
	localparam logic [1:0] CHIP_RESET    = CHIP_AY8912;

	localparam logic [7:0] BYTE_ONES = 8'hff;

	typedef struct packed {
		logic [2:0] bus_control;
		logic [7:0] data_bus;
		logic [7:0] port_a_pins;
		logic [7:0] port_b_pins;
	} in_item_t;

	typedef struct packed {
		logic [7:0]           read_data;
		logic [7:0]           port_a_drive;
		logic [7:0]           port_b_drive;
		logic                 audio_write;
		logic [REG_IDX_W-1:0] audio_register;
		logic [7:0]           audio_value;
	} out_item_t;

	// register file update request from the decoder
	typedef struct packed {
		logic                 latch_en;
		logic [7:0]           latch_addr;
		logic                 wr_en;
		logic [REG_IDX_W-1:0] wr_idx;
		logic [7:0]           wr_val;
	} wr_req_t;

	typedef struct packed {
		logic [REG_COUNT-1:0][7:0] regs;
		logic [7:0]                sel_addr;
		logic [1:0]                chip_type;
	} psg_state_t;

	function automatic logic [7:0] reg_mask(input logic [REG_IDX_W-1:0] idx);
		logic [7:0] m;
		unique case (idx)
			4'd1, 4'd3, 4'd5, 4'd13:  m = 8'h0f;
			4'd6, 4'd8, 4'd9, 4'd10:  m = 8'h1f;
			default:                  m = 8'hff;
		endcase
		return m;
	endfunction

endpackage

// ===== rtl/psg_stream_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psg_stream_if
// Valid/ready channel carrying one item of a given payload type.
// ----------------------------------------------------------------------------
interface psg_stream_if #(parameter type T = logic);
	logic valid;
	logic ready;
	T     payload;

	modport source (output valid, output payload, input ready);
	modport sink   (input valid, input payload, output ready);
endinterface

// ===== rtl/psg_register_bus_interface_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psg_register_bus_interface_top
// PSG bus interface: one bus cycle in, one result with read byte, port drive
// levels and audio register write out.
// Pipeline: input register, then result register, from accept to result.
// Throughput: 1 item per cycle while the output accepts results, set by the single
// decode stage; the result register lets a new item enter while a finished result waits.
// Reset: registers and selected address clear to zero, chip type to AY8912.
// ----------------------------------------------------------------------------
module psg_register_bus_interface_top
	import psg_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	psg_stream_if.sink   in_ch,
	psg_stream_if.source out_ch,
	psg_stream_if.sink   cfg_ch
);

	logic       valid_s1, valid_s2;
	in_item_t   item_s1;
	out_item_t  result_s2;
	logic       advance;
	psg_state_t state;
	wr_req_t    req;
	out_item_t  result;

	assign advance      = valid_s1 && (!valid_s2 || out_ch.ready);
	assign in_ch.ready  = !valid_s1 || advance;
	assign cfg_ch.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (in_ch.ready) begin
				valid_s1 <= in_ch.valid;
			end
			if (advance) begin
				valid_s2 <= 1'b1;
			end else if (out_ch.ready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_ch.valid && in_ch.ready) begin
			item_s1 <= in_ch.payload;
		end
		if (advance) begin
			result_s2 <= result;
		end
	end

	psg_regs u_regs (
		.clk      (clk),
		.arst_n   (arst_n),
		.upd_en   (advance),
		.req      (req),
		.cfg_we   (cfg_ch.valid && cfg_ch.ready),
		.cfg_data (cfg_ch.payload),
		.state    (state)
	);

	psg_decode u_decode (
		.item   (item_s1),
		.state  (state),
		.req    (req),
		.result (result)
	);

	assign out_ch.valid   = valid_s2;
	assign out_ch.payload = result_s2;

	a_audio_reg_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid && out_ch.payload.audio_write
		|-> out_ch.payload.audio_register != PORT_A_REG
		&& out_ch.payload.audio_register != PORT_B_REG)
		else $error("audio write to a port register");

	a_audio_idle_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid && !out_ch.payload.audio_write
		|-> out_ch.payload.audio_register == '0 && out_ch.payload.audio_value == 8'h00)
		else $error("audio fields not zero without audio write");

	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ch.ready |-> valid_s1 && valid_s2 && !out_ch.ready)
		else $error("input stalled while pipeline has room");

	a_write_only_on_advance: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !advance |=> valid_s1 && $stable(item_s1))
		else $error("stalled input stage lost its item");

endmodule

// ===== rtl/psg_regs.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psg_regs
// Register file, selected address and chip type register.
// ----------------------------------------------------------------------------
module psg_regs
	import psg_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       upd_en,
	input  wr_req_t    req,
	input  logic       cfg_we,
	input  logic [1:0] cfg_data,
	output psg_state_t state
);

	logic [REG_COUNT-1:0][7:0] regs_q;
	logic [7:0]                sel_addr_q;
	logic [1:0]                chip_type_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q      <= '0;
			sel_addr_q  <= '0;
			chip_type_q <= CHIP_RESET;
		end else begin
			if (upd_en && req.latch_en) begin
				sel_addr_q <= req.latch_addr;
			end
			if (upd_en && req.wr_en) begin
				regs_q[req.wr_idx] <= req.wr_val;
			end
			if (cfg_we) begin
				chip_type_q <= cfg_data;
			end
		end
	end

	assign state.regs      = regs_q;
	assign state.sel_addr  = sel_addr_q;
	assign state.chip_type = chip_type_q;

endmodule

// ===== rtl/psg_decode.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psg_decode
// Bus cycle decode: latch/read/write handling, port mix and drive levels.
// ----------------------------------------------------------------------------
module psg_decode
	import psg_pkg::*;
(
	input  in_item_t   item,
	input  psg_state_t state,
	output wr_req_t    req,
	output out_item_t  result
);

	logic                 is_latch, is_read, is_write;
	logic                 addr_ok;
	logic [REG_IDX_W-1:0] idx;
	logic [7:0]           wr_val;
	logic [7:0]           r7_n, r14_n, r15_n;
	logic [7:0]           m_a, m_b;
	logic [7:0]           rd_port_m, pins, rd_val;
	logic                 port_b_sel;

	always_comb begin
		is_latch = 1'b0;
		is_read  = 1'b0;
		is_write = 1'b0;
		unique case (item.bus_control)
			BUS_LATCH_BC1, BUS_LATCH_BDIR, BUS_LATCH_ALL: is_latch = 1'b1;
			BUS_READ:                                     is_read  = 1'b1;
			BUS_WRITE:                                    is_write = 1'b1;
			default:                                      ;
		endcase
	end

	assign addr_ok = (state.sel_addr[7:REG_IDX_W] == '0);
	assign idx     = state.sel_addr[REG_IDX_W-1:0];
	assign wr_val  = item.data_bus & reg_mask(idx);

	assign req.latch_en   = is_latch;
	assign req.latch_addr = item.data_bus;
	assign req.wr_en      = is_write && addr_ok;
	assign req.wr_idx     = idx;
	assign req.wr_val     = wr_val;

	// drive levels reflect this cycle's write
	assign r7_n  = (req.wr_en && idx == MIXER_REG)  ? wr_val : state.regs[MIXER_REG];
	assign r14_n = (req.wr_en && idx == PORT_A_REG) ? wr_val : state.regs[PORT_A_REG];
	assign r15_n = (req.wr_en && idx == PORT_B_REG) ? wr_val : state.regs[PORT_B_REG];
	assign m_a   = r7_n[MIX_DIR_A_BIT] ? 8'h00 : BYTE_ONES;
	assign m_b   = r7_n[MIX_DIR_B_BIT] ? 8'h00 : BYTE_ONES;

	// read path, uses state before this cycle
	assign port_b_sel = (idx == PORT_B_REG);
	assign rd_port_m  = state.regs[MIXER_REG][port_b_sel ? MIX_DIR_B_BIT : MIX_DIR_A_BIT]
		? 8'h00 : BYTE_ONES;

	always_comb begin
		if (!port_b_sel) begin
			pins = item.port_a_pins;
		end else if (state.chip_type == CHIP_AY8912) begin
			pins = BYTE_ONES;
		end else begin
			pins = item.port_b_pins;
		end
	end

	always_comb begin
		priority if (!addr_ok) begin
			rd_val = BYTE_ONES;
		end else if (idx != PORT_A_REG && idx != PORT_B_REG) begin
			rd_val = state.regs[idx] & reg_mask(idx);
		end else if (state.chip_type == CHIP_YMZ284) begin
			rd_val = BYTE_ONES;
		end else begin
			rd_val = (pins & rd_port_m) | (state.regs[idx] & pins & ~rd_port_m);
		end
	end

	assign result.read_data      = is_read ? rd_val : BYTE_ONES;
	assign result.port_a_drive   = m_a | (r14_n & ~m_a);
	assign result.port_b_drive   = m_b | (r15_n & ~m_b);
	assign result.audio_write    = req.wr_en && (idx < PORT_A_REG);
	assign result.audio_register = result.audio_write ? idx : '0;
	assign result.audio_value    = result.audio_write ? wr_val : 8'h00;

endmodule

// ===== verif/psg_bus_shadow_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psg_bus_shadow_pkg
// Shadow copy of the PSG register file and address latch. It works out the
// result of every accepted bus cycle and checks the block's results in order.
// ----------------------------------------------------------------------------
package psg_bus_shadow_pkg;
	import psg_pkg::*;

	class psg_bus_shadow;
		logic [7:0] regs [REG_COUNT];
		logic [7:0] sel_addr;
		logic [1:0] chip;
		out_item_t  cycle_results_q [$];
		int         bad_results;

		function new();
			foreach (regs[i]) regs[i] = 8'h00;
			sel_addr    = 8'h00;
			chip        = CHIP_RESET;
			bad_results = 0;
		endfunction

		function void set_chip_type(input logic [1:0] value);
			chip = value;
		endfunction

		function int cycles_pending();
			return cycle_results_q.size();
		endfunction

		// bits that exist in each register
		function logic [7:0] field_mask(input logic [7:0] idx);
			case (idx)
				8'd1, 8'd3, 8'd5, 8'd13: return 8'h0f;
				8'd6, 8'd8, 8'd9, 8'd10: return 8'h1f;
				default:                 return 8'hff;
			endcase
		endfunction

		// all ones while the port is an input
		function logic [7:0] input_mask(input bit port_b);
			logic dir_out;
			dir_out = port_b ? regs[MIXER_REG][MIX_DIR_B_BIT] : regs[MIXER_REG][MIX_DIR_A_BIT];
			return dir_out ? 8'h00 : 8'hff;
		endfunction

		function logic [7:0] port_level(input bit port_b);
			logic [7:0] m;
			logic [7:0] latch_val;
			m         = input_mask(port_b);
			latch_val = port_b ? regs[PORT_B_REG] : regs[PORT_A_REG];
			return m | (latch_val & ~m);
		endfunction

		function logic [7:0] read_selected(input logic [7:0] pa, input logic [7:0] pb);
			bit         port_b;
			logic [7:0] pins;
			logic [7:0] m;
			if (sel_addr < PORT_A_REG)
				return regs[sel_addr[3:0]] & field_mask(sel_addr);
			if (sel_addr >= REG_COUNT)
				return 8'hff;
			if (chip == CHIP_YMZ284)
				return 8'hff;
			port_b = (sel_addr[3:0] == PORT_B_REG);
			if (!port_b)
				pins = pa;
			else if (chip == CHIP_AY8912)
				pins = 8'hff;
			else
				pins = pb;
			m = input_mask(port_b);
			return (pins & m) | (regs[sel_addr[3:0]] & pins & ~m);
		endfunction

		function out_item_t run_bus_cycle(input in_item_t c);
			out_item_t  r;
			logic [7:0] v;
			r.read_data      = 8'hff;
			r.audio_write    = 1'b0;
			r.audio_register = '0;
			r.audio_value    = 8'h00;
			case (c.bus_control)
				BUS_LATCH_BC1, BUS_LATCH_BDIR, BUS_LATCH_ALL: sel_addr = c.data_bus;
				BUS_READ: r.read_data = read_selected(c.port_a_pins, c.port_b_pins);
				BUS_WRITE: begin
					if (sel_addr < REG_COUNT) begin
						v = c.data_bus & field_mask(sel_addr);
						regs[sel_addr[3:0]] = v;
						if (sel_addr < PORT_A_REG) begin
							r.audio_write    = 1'b1;
							r.audio_register = sel_addr[3:0];
							r.audio_value    = v;
						end
					end
				end
				default: ;
			endcase
			// drive levels reflect this cycle's write
			r.port_a_drive = port_level(1'b0);
			r.port_b_drive = port_level(1'b1);
			return r;
		endfunction

		function void note_bus_cycle(input in_item_t c);
			cycle_results_q.push_back(run_bus_cycle(c));
		endfunction

		function void field_check(input string name, input logic [7:0] want,
			input logic [7:0] got);
			if (got !== want) begin
				bad_results++;
				$display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
			end
		endfunction

		function void check_bus_result(input out_item_t got);
			out_item_t want;
			if (cycle_results_q.size() == 0) begin
				bad_results++;
				$display("%0t: unexpected result, expected none, actual %h", $time, got);
				return;
			end
			want = cycle_results_q.pop_front();
			field_check("read_data", want.read_data, got.read_data);
			field_check("port_a_drive", want.port_a_drive, got.port_a_drive);
			field_check("port_b_drive", want.port_b_drive, got.port_b_drive);
			field_check("audio_write", 8'(want.audio_write), 8'(got.audio_write));
			field_check("audio_register", 8'(want.audio_register), 8'(got.audio_register));
			field_check("audio_value", want.audio_value, got.audio_value);
		endfunction
	endclass

endpackage

// ===== verif/psg_register_bus_interface_top_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psg_register_bus_interface_top_test
// Drives bus cycles (latch, read, write, inactive) into the PSG bus interface
// under every chip type, with random gaps and stalls on both channels, and
// checks each result against a shadow register file.
// ----------------------------------------------------------------------------
module psg_register_bus_interface_top_test;
	import psg_pkg::*;
	import psg_bus_shadow_pkg::*;

	localparam logic [2:0] BUS_IDLE_NONE     = 3'd0;
	localparam logic [2:0] BUS_IDLE_BC2      = 3'd2;
	localparam logic [2:0] BUS_IDLE_BDIR_BC1 = 3'd5;
	localparam logic [1:0] CHIP_UNDEFINED    = 2'd3;
	localparam int         CYCLE_LIMIT       = 300000;

	logic clk;
	logic arst_n;
	bit   gaps_on = 1'b1;
	int   out_hold_left = 0;
	int   cycle_count = 0;

	psg_bus_shadow shadow = new();

	psg_stream_if #(.T(in_item_t))   bus_in_if ();
	psg_stream_if #(.T(out_item_t))  bus_out_if ();
	psg_stream_if #(.T(logic [1:0])) chip_cfg_if ();

	psg_register_bus_interface_top i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (bus_in_if),
		.out_ch (bus_out_if),
		.cfg_ch (chip_cfg_if)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("psg_register_bus_interface_top test failed");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (bus_out_if.valid && bus_out_if.ready)
				shadow.check_bus_result(bus_out_if.payload);
			if (bus_in_if.valid && bus_in_if.ready)
				shadow.note_bus_cycle(bus_in_if.payload);
		end
	end

	// result side: random stalls, plus a long hold-off on request
	initial begin
		bus_out_if.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (out_hold_left > 0) begin
				bus_out_if.ready <= 1'b0;
				out_hold_left--;
			end else begin
				bus_out_if.ready <= !(gaps_on && $urandom_range(0, 99) < 23);
			end
		end
	end

	task automatic drive_bus_cycle(input logic [2:0] ctl, input logic [7:0] data,
		input logic [7:0] pa, input logic [7:0] pb);
		in_item_t c;
		c.bus_control = ctl;
		c.data_bus    = data;
		c.port_a_pins = pa;
		c.port_b_pins = pb;
		while (gaps_on && $urandom_range(0, 99) < 23) begin
			bus_in_if.valid <= 1'b0;
			@(posedge clk);
		end
		bus_in_if.valid   <= 1'b1;
		bus_in_if.payload <= c;
		do @(posedge clk); while (!bus_in_if.ready);
	endtask

	// stop offering until every outstanding result is back
	task automatic drain_results();
		bus_in_if.valid <= 1'b0;
		do @(posedge clk); while (shadow.cycles_pending() != 0);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_chip_type(input logic [1:0] value);
		chip_cfg_if.valid   <= 1'b1;
		chip_cfg_if.payload <= value;
		do @(posedge clk); while (!chip_cfg_if.ready);
		chip_cfg_if.valid <= 1'b0;
		shadow.set_chip_type(value);
	endtask

	function automatic logic [7:0] rand_byte();
		return 8'($urandom_range(0, 255));
	endfunction

	function automatic logic [2:0] latch_code();
		case ($urandom_range(0, 2))
			0:       return BUS_LATCH_BC1;
			1:       return BUS_LATCH_BDIR;
			default: return BUS_LATCH_ALL;
		endcase
	endfunction

	// mostly real registers, weighted toward the mixer and port registers
	function automatic logic [7:0] pick_address();
		int r;
		r = $urandom_range(0, 99);
		if (r < 12)
			return 8'($urandom_range(REG_COUNT, 255));
		if (r < 20)
			return 8'(MIXER_REG);
		if (r < 35)
			return 8'($urandom_range(PORT_A_REG, PORT_B_REG));
		return 8'($urandom_range(0, REG_COUNT - 1));
	endfunction

	task automatic random_traffic(input int count);
		int         sent;
		int         kind;
		int         reads;
		logic [2:0] ctl;
		sent = 0;
		while (sent < count) begin
			kind = $urandom_range(0, 99);
			if (kind < 40) begin
				drive_bus_cycle(latch_code(), pick_address(), rand_byte(), rand_byte());
				drive_bus_cycle(BUS_WRITE, rand_byte(), rand_byte(), rand_byte());
				sent += 2;
			end else if (kind < 70) begin
				drive_bus_cycle(latch_code(), pick_address(), rand_byte(), rand_byte());
				reads = $urandom_range(1, 3);
				repeat (reads)
					drive_bus_cycle(BUS_READ, rand_byte(), rand_byte(), rand_byte());
				sent += 1 + reads;
			end else if (kind < 80) begin
				drive_bus_cycle(($urandom_range(0, 1) != 0) ? BUS_READ : BUS_WRITE,
					rand_byte(), rand_byte(), rand_byte());
				sent++;
			end else begin
				ctl = 3'($urandom_range(0, 7));
				drive_bus_cycle(ctl, rand_byte(), rand_byte(), rand_byte());
				if (ctl != BUS_IDLE_NONE && ctl != BUS_IDLE_BC2 && ctl != BUS_IDLE_BDIR_BC1)
					sent++;
			end
		end
	endtask

	task automatic directed_checks();
		drive_bus_cycle(BUS_READ, 8'h00, 8'h00, 8'hff);
		// both ports to output, then load the output latches
		drive_bus_cycle(BUS_LATCH_BC1, 8'(MIXER_REG), 8'h00, 8'h00);
		drive_bus_cycle(BUS_WRITE, 8'hc0, 8'h00, 8'h00);
		drive_bus_cycle(BUS_LATCH_BDIR, 8'(PORT_A_REG), 8'h00, 8'h00);
		drive_bus_cycle(BUS_WRITE, 8'ha5, 8'h00, 8'h00);
		drive_bus_cycle(BUS_READ, 8'h00, 8'hff, 8'h00);
		drive_bus_cycle(BUS_LATCH_ALL, 8'(PORT_B_REG), 8'h00, 8'h00);
		drive_bus_cycle(BUS_WRITE, 8'h5a, 8'h00, 8'h00);
		drive_bus_cycle(BUS_READ, 8'hff, 8'h00, 8'h00);
		// masked writes reach the audio side
		drive_bus_cycle(BUS_LATCH_BC1, 8'd1, 8'hff, 8'hff);
		drive_bus_cycle(BUS_WRITE, 8'hff, 8'hff, 8'hff);
		drive_bus_cycle(BUS_READ, 8'h00, 8'hff, 8'hff);
		drive_bus_cycle(BUS_LATCH_BDIR, 8'd13, 8'h00, 8'h00);
		drive_bus_cycle(BUS_WRITE, 8'hff, 8'h00, 8'h00);
		// out of range address: write dropped, read gives all ones
		drive_bus_cycle(BUS_LATCH_ALL, 8'd16, 8'h00, 8'h00);
		drive_bus_cycle(BUS_WRITE, 8'h77, 8'h00, 8'h00);
		drive_bus_cycle(BUS_READ, 8'h00, 8'h00, 8'h00);
		drive_bus_cycle(BUS_LATCH_BC1, 8'hff, 8'h00, 8'h00);
		drive_bus_cycle(BUS_READ, 8'h00, 8'h00, 8'h00);
		drive_bus_cycle(BUS_IDLE_NONE, 8'h00, 8'hff, 8'hff);
		drive_bus_cycle(BUS_IDLE_BC2, 8'hff, 8'h00, 8'h00);
		drive_bus_cycle(BUS_IDLE_BDIR_BC1, 8'h0e, 8'hff, 8'h00);
		// back to inputs: pins pass straight through
		drive_bus_cycle(BUS_LATCH_BC1, 8'(MIXER_REG), 8'h00, 8'h00);
		drive_bus_cycle(BUS_WRITE, 8'h00, 8'h00, 8'h00);
		drive_bus_cycle(BUS_LATCH_ALL, 8'(PORT_A_REG), 8'h00, 8'h00);
		drive_bus_cycle(BUS_READ, 8'h00, 8'h3c, 8'hc3);
	endtask

	initial begin
		arst_n              <= 1'b0;
		bus_in_if.valid     <= 1'b0;
		bus_in_if.payload   <= '0;
		chip_cfg_if.valid   <= 1'b0;
		chip_cfg_if.payload <= CHIP_RESET;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset chip type first
		directed_checks();
		gaps_on = 1'b0;
		random_traffic(150);
		gaps_on = 1'b1;
		drain_results();

		write_chip_type(CHIP_AY);
		random_traffic(60);
		out_hold_left = 80;
		random_traffic(80);
		drain_results();
		random_traffic(60);
		drain_results();

		write_chip_type(CHIP_YMZ284);
		random_traffic(150);
		drain_results();

		write_chip_type(CHIP_UNDEFINED);
		random_traffic(150);
		drain_results();

		write_chip_type(CHIP_AY8912);
		random_traffic(150);
		drain_results();
		repeat (8) @(posedge clk);

		if (shadow.bad_results == 0 && shadow.cycles_pending() == 0)
			$display("psg_register_bus_interface_top test passed");
		else
			$display("psg_register_bus_interface_top test failed");
		$finish;
	end

endmodule

// ===== filelist.f =====
rtl/psg_pkg.sv
rtl/psg_stream_if.sv
rtl/psg_regs.sv
rtl/psg_decode.sv
rtl/psg_register_bus_interface_top.sv
verif/psg_bus_shadow_pkg.sv
verif/psg_register_bus_interface_top_test.sv
